// File: rtl/uvs_pkg.sv
// shared constants for the uv sphere mesh generator
package uvs_pkg;

    // clamp floors for the mesh counts
    localparam logic [7:0] SEG_MIN  = 8'd3;
    localparam logic [7:0] RING_MIN = 8'd2;

    // last corner of the six per quad
    localparam logic [2:0] CORNER_LAST = 3'd5;

    // register indexes on the configuration port
    localparam logic REG_SEGMENTS = 1'b0;
    localparam logic REG_RINGS    = 1'b1;

    // record kinds on the output stream
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // divisor width of the shared divider (twice the largest count)
    localparam int DIV_DW = 10;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// File: rtl/uvs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module uvs_div #(
    parameter int NW = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NW-1:0]              i_num,
    input  logic [uvs_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [NW-1:0]              o_quo
);

    localparam int DW = uvs_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic          w_ge;
    logic [DW:0]   w_diff;

    // one trial subtraction per cycle
    assign w_sh   = {r_rem, r_q[NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: rtl/uvs_sine_rom.sv
// quarter-wave sine rom with quadrant folding, registered read
module uvs_sine_rom #(
    parameter int PHASE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic [14:0]           o_mag,
    output logic                  o_neg
);

    localparam int QTR = 1 << (PHASE_BITS - 2);
    localparam int AW  = PHASE_BITS - 1;

    logic [14:0]           w_tab [0:QTR];
    logic [1:0]            w_quad;
    logic [PHASE_BITS-3:0] w_k;
    logic [AW-1:0]         w_addr;
    logic [14:0]           r_mag;
    logic                  r_neg;

    // table contents: integer taylor series of sin, worked out at elaboration
    for (genvar k = 0; k <= QTR; k++) begin : g_tab
        localparam logic [63:0] X  = (64'(k) * uvs_pkg::HALF_PI_Q30 + 64'(QTR / 2))
                                     >> (PHASE_BITS - 2);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] M1 = ((X  * X2) >> 30) / 6;
        localparam logic [63:0] M2 = ((M1 * X2) >> 30) / 20;
        localparam logic [63:0] M3 = ((M2 * X2) >> 30) / 42;
        localparam logic [63:0] M4 = ((M3 * X2) >> 30) / 72;
        localparam logic [63:0] M5 = ((M4 * X2) >> 30) / 110;
        localparam logic [63:0] M6 = ((M5 * X2) >> 30) / 156;
        localparam logic [63:0] M7 = ((M6 * X2) >> 30) / 210;
        localparam logic [63:0] M8 = ((M7 * X2) >> 30) / 272;
        localparam logic [63:0] POS = X + M2 + M4 + M6 + M8;
        localparam logic [63:0] NEG = M1 + M3 + M5 + M7;
        localparam logic [63:0] ACC = (POS >= NEG) ? POS - NEG : 64'd0;
        localparam logic [63:0] RND = (ACC + 64'd16384) >> 15;
        localparam logic [63:0] VAL = (RND > 64'd32767) ? 64'd32767 : RND;
        assign w_tab[k] = VAL[14:0];
    end

    // fold the phase into the first quadrant
    assign w_quad = i_phase[PHASE_BITS-1 -: 2];
    assign w_k    = i_phase[PHASE_BITS-3:0];
    assign w_addr = w_quad[0] ? AW'(QTR) - AW'(w_k) : AW'(w_k);

    // registered read
    always_ff @(posedge i_clk) begin
        r_mag <= w_tab[w_addr];
        r_neg <= w_quad[1];
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

// File: rtl/uv_sphere_mesh_generator.sv
// uv sphere mesh generator top level: counters, sequencer, output register
//
// Each request on the input stream produces one record of a uv sphere of
// radius one half: first every vertex ring by ring, then six triangle corner
// indices per quad, then the stream wraps. Most of the work on a vertex
// record lies in the bit-serial divider, which works out in turn the phi
// and theta phases and the u and v texture coordinates one quotient bit
// per cycle; the sine values then come from a synchronous quarter-wave
// rom, four reads, and one shared 15x15 multiplier forms the x and z
// normals. A new request is taken whenever the sequencer is idle, even
// while the previous record still waits on the output. Counts are written
// through the apb port at address 0 (segments) and 4 (rings).
module uv_sphere_mesh_generator #(
    parameter int PHASE_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [0] restart
    // record stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z, [63:48] pos_x,
    // [79:64] pos_y, [95:80] pos_z, [112:96] tex_u, [129:113] tex_v,
    // [145:130] vertex_index
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tuser,  // [0] item_kind
    output logic         m_axis_tlast,  // last_item
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NW = (PHASE_BITS + 10 > 24) ? PHASE_BITS + 10 : 24;
    localparam int DW = uvs_pkg::DIV_DW;
    localparam logic [PHASE_BITS-1:0] QTR = PHASE_BITS'(1) << (PHASE_BITS - 2);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ROM, ST_MUL, ST_OUT} t_state;

    t_state r_state;

    // configuration and stream counters
    logic [7:0] r_seg, r_ring;
    logic       r_phase;
    logic [7:0] r_ring_cnt, r_seg_cnt;
    logic [2:0] r_corner;

    // work registers of the record in flight
    logic                  r_kind, r_last;
    logic [7:0]            r_r, r_s;
    logic [2:0]            r_wcorner;
    logic [16:0]           r_a;
    logic [1:0]            r_step;
    logic [2:0]            r_rcnt;
    logic [1:0]            r_mcnt;
    logic                  r_div_start;
    logic [PHASE_BITS-1:0] r_pphi, r_pth;
    logic [16:0]           r_tu, r_tv;
    logic [14:0]           r_sp_mag, r_cp_mag, r_st_mag, r_ct_mag;
    logic                  r_sp_neg, r_cp_neg, r_st_neg, r_ct_neg;
    logic [29:0]           r_prod;
    logic [15:0]           r_nx, r_nz;

    // output register
    logic         r_mv, r_muser, r_mlast;
    logic [151:0] r_mtdata;

    logic [7:0]  w_S, w_R;
    logic        w_acc, w_restart;
    logic        w_c_phase;
    logic [7:0]  w_c_r, w_c_s;
    logic [2:0]  w_c_corner;
    logic        w_oor;
    logic        e_phase;
    logic [7:0]  e_r, e_s;
    logic [2:0]  e_corner;
    logic [16:0] w_a;
    logic        w_cfg_wr;

    logic [NW-1:0]         w_num;
    logic [DW-1:0]         w_den;
    logic                  w_div_done;
    logic [NW-1:0]         w_quo;
    logic [PHASE_BITS-1:0] w_rom_phase;
    logic [14:0]           w_rom_mag;
    logic                  w_rom_neg;
    logic [14:0]           w_mul_b;
    logic [15:0]           w_m;
    logic [15:0]           w_ny;
    logic [16:0]           w_b;
    logic [16:0]           w_v;
    logic                  w_out_free;

    // clamped counts
    assign w_S = (r_seg  < uvs_pkg::SEG_MIN)  ? uvs_pkg::SEG_MIN  : r_seg;
    assign w_R = (r_ring < uvs_pkg::RING_MIN) ? uvs_pkg::RING_MIN : r_ring;

    // apb port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = {24'd0, (paddr[2] == uvs_pkg::REG_RINGS) ? r_ring : r_seg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg  <= 8'd16;
            r_ring <= 8'd8;
        end else if (w_cfg_wr) begin
            if (paddr[2] == uvs_pkg::REG_RINGS) begin
                r_ring <= pwdata[7:0];
            end else begin
                r_seg <= pwdata[7:0];
            end
        end
    end

    // request handshake and counters after restart and range checks
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];
    assign w_c_phase     = w_restart ? 1'b0 : r_phase;
    assign w_c_r         = w_restart ? 8'd0 : r_ring_cnt;
    assign w_c_s         = w_restart ? 8'd0 : r_seg_cnt;
    assign w_c_corner    = w_restart ? 3'd0 : r_corner;
    assign w_oor = w_c_phase ? (w_c_r >= w_R || w_c_s >= w_S ||
                                w_c_corner > uvs_pkg::CORNER_LAST)
                             : (w_c_r > w_R || w_c_s > w_S);
    assign e_phase  = w_oor ? 1'b0 : w_c_phase;
    assign e_r      = w_oor ? 8'd0 : w_c_r;
    assign e_s      = w_oor ? 8'd0 : w_c_s;
    assign e_corner = w_oor ? 3'd0 : w_c_corner;
    assign w_a      = 17'(e_r) * (17'(w_S) + 17'd1) + 17'(e_s);

    // stream position advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_ring_cnt <= '0;
            r_seg_cnt  <= '0;
            r_corner   <= '0;
        end else if (w_acc) begin
            r_phase    <= e_phase;
            r_ring_cnt <= e_r;
            r_seg_cnt  <= e_s;
            r_corner   <= e_corner;
            if (!e_phase) begin
                if (e_s < w_S) begin
                    r_seg_cnt <= e_s + 1'b1;
                end else begin
                    r_seg_cnt <= '0;
                    if (e_r < w_R) begin
                        r_ring_cnt <= e_r + 1'b1;
                    end else begin
                        r_ring_cnt <= '0;
                        r_corner   <= '0;
                        r_phase    <= 1'b1;
                    end
                end
            end else if (e_corner < uvs_pkg::CORNER_LAST) begin
                r_corner <= e_corner + 1'b1;
            end else begin
                r_corner <= '0;
                if (9'(e_s) + 9'd1 < 9'(w_S)) begin
                    r_seg_cnt <= e_s + 1'b1;
                end else begin
                    r_seg_cnt <= '0;
                    if (9'(e_r) + 9'd1 < 9'(w_R)) begin
                        r_ring_cnt <= e_r + 1'b1;
                    end else begin
                        r_phase    <= 1'b0;
                        r_ring_cnt <= '0;
                    end
                end
            end
        end
    end

    // divider job select: phi phase, theta phase, u, v
    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_num = (NW'(r_r) << PHASE_BITS) + NW'(w_R);
                w_den = DW'(w_R) << 1;
            end
            2'd1: begin
                w_num = (NW'(r_s) << (PHASE_BITS + 1)) + NW'(w_S);
                w_den = DW'(w_S) << 1;
            end
            2'd2: begin
                w_num = NW'(r_s) << 16;
                w_den = DW'(w_S);
            end
            default: begin
                w_num = NW'(r_r) << 16;
                w_den = DW'(w_R);
            end
        endcase
    end

    uvs_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // rom lookup select: sin phi, cos phi, sin theta, cos theta
    always_comb begin
        unique case (r_rcnt[1:0])
            2'd0:    w_rom_phase = r_pphi;
            2'd1:    w_rom_phase = r_pphi + QTR;
            2'd2:    w_rom_phase = r_pth;
            default: w_rom_phase = r_pth + QTR;
        endcase
    end

    uvs_sine_rom #(.PHASE_BITS(PHASE_BITS)) u_rom (
        .i_clk   (i_clk),
        .i_phase (w_rom_phase),
        .o_mag   (w_rom_mag),
        .o_neg   (w_rom_neg)
    );

    // shared multiplier, rounding half up on magnitudes
    assign w_mul_b = (r_mcnt == 2'd0) ? r_ct_mag : r_st_mag;
    assign w_m     = 16'((r_prod + 30'd16384) >> 15);
    assign w_ny    = r_cp_neg ? -{1'b0, r_cp_mag} : {1'b0, r_cp_mag};

    // index record corner
    assign w_b = r_a + 17'(w_S) + 17'd1;
    always_comb begin
        unique case (r_wcorner)
            3'd0:       w_v = r_a;
            3'd1, 3'd4: w_v = w_b;
            3'd2, 3'd3: w_v = r_a + 17'd1;
            default:    w_v = w_b + 17'd1;
        endcase
    end

    assign w_out_free = !r_mv || m_axis_tready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_step      <= '0;
            r_rcnt      <= '0;
            r_mcnt      <= '0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_step <= '0;
                        if (e_phase) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state     <= ST_DIV;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (r_step == 2'd3) begin
                            r_state <= ST_ROM;
                            r_rcnt  <= '0;
                        end else begin
                            r_step      <= r_step + 1'b1;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                ST_ROM: begin
                    if (r_rcnt == 3'd4) begin
                        r_state <= ST_MUL;
                        r_mcnt  <= '0;
                    end else begin
                        r_rcnt <= r_rcnt + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (r_mcnt == 2'd2) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // work datapath
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind    <= e_phase;
            r_r       <= e_r;
            r_s       <= e_s;
            r_wcorner <= e_corner;
            r_a       <= w_a;
            r_last    <= e_phase && (e_corner == uvs_pkg::CORNER_LAST) &&
                         (9'(e_s) + 9'd1 >= 9'(w_S)) && (9'(e_r) + 9'd1 >= 9'(w_R));
        end
        if (r_state == ST_DIV && w_div_done) begin
            unique case (r_step)
                2'd0:    r_pphi <= w_quo[PHASE_BITS-1:0];
                2'd1:    r_pth  <= w_quo[PHASE_BITS-1:0];
                2'd2:    r_tu   <= w_quo[16:0];
                default: r_tv   <= w_quo[16:0];
            endcase
        end
        if (r_state == ST_ROM) begin
            unique case (r_rcnt)
                3'd1: begin
                    r_sp_mag <= w_rom_mag;
                    r_sp_neg <= w_rom_neg;
                end
                3'd2: begin
                    r_cp_mag <= w_rom_mag;
                    r_cp_neg <= w_rom_neg;
                end
                3'd3: begin
                    r_st_mag <= w_rom_mag;
                    r_st_neg <= w_rom_neg;
                end
                3'd4: begin
                    r_ct_mag <= w_rom_mag;
                    r_ct_neg <= w_rom_neg;
                end
                default: ;
            endcase
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_sp_mag * w_mul_b;
            if (r_mcnt == 2'd1) begin
                r_nx <= (r_sp_neg ^ r_ct_neg) ? -w_m : w_m;
            end
            if (r_mcnt == 2'd2) begin
                r_nz <= (r_sp_neg ^ r_st_neg) ? -w_m : w_m;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_mv <= 1'b1;
        end else if (m_axis_tready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            if (r_kind == uvs_pkg::KIND_INDEX) begin
                r_muser  <= uvs_pkg::KIND_INDEX;
                r_mlast  <= r_last;
                r_mtdata <= {6'd0, w_v[15:0], 130'd0};
            end else begin
                r_muser  <= uvs_pkg::KIND_VERTEX;
                r_mlast  <= 1'b0;
                r_mtdata <= {6'd0, r_a[15:0], r_tv, r_tu,
                             $signed(r_nz) >>> 1, $signed(w_ny) >>> 1,
                             $signed(r_nx) >>> 1, r_nz, w_ny, r_nx};
            end
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mtdata;
    assign m_axis_tuser  = r_muser;
    assign m_axis_tlast  = r_mlast;

    // checks
    a_last_on_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == uvs_pkg::KIND_INDEX)
        else $error("last flag on a vertex record");

    a_index_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_INDEX |-> r_mtdata[129:0] == '0)
        else $error("index record carries vertex data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> r_state == ST_DIV)
        else $error("divider started outside the divide phase");

endmodule

// File: tb/uv_sphere_mesh_generator_tb.sv
// testbench for the uv sphere mesh generator: directed and random record streams
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_tb;

    localparam int PB      = 12;
    localparam int QTR     = 1 << (PB - 2);
    localparam int LIMIT   = 2000000;
    localparam int SETTLE  = 300;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [15:0] nx, ny, nz, px, py, pz;
        logic [16:0] u, v;
        logic [15:0] idx;
    } t_mesh_rec;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    uv_sphere_mesh_generator #(.PHASE_BITS(PB)) i_dut (.*);

    // predictor state
    int unsigned seg_reg, ring_reg;
    int unsigned idx_phase, ring_ctr, seg_ctr, corner_ctr;
    int          sine_rom [0:QTR];

    t_mesh_rec   pending_recs [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          timed_out = 1'b0;
    int          idle_pct;

    // clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("uv_sphere_mesh_generator_tb NOT OK");
            $finish;
        end
    end

    // quarter-wave sine by integer series
    function automatic int quarter_sine(int unsigned k);
        longint unsigned x, x2, mag, r;
        longint          acc;
        if (k > QTR) k = QTR;
        x = (64'(k) * uvs_pkg::HALF_PI_Q30 + (QTR >> 1)) >> (PB - 2);
        x2 = (x * x) >> 30;
        acc = longint'(x);
        mag = x;
        for (int n = 1; n <= 8; n++) begin
            mag = ((mag * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n & 1) acc -= longint'(mag);
            else acc += longint'(mag);
        end
        if (acc < 0) acc = 0;
        r = (longint'(acc) + 16384) >> 15;
        if (r > 32767) r = 32767;
        return int'(r);
    endfunction

    function automatic int sine_of(int unsigned p);
        int unsigned q, k;
        int          s;
        p &= (1 << PB) - 1;
        q = p >> (PB - 2);
        k = p & (QTR - 1);
        s = (q & 1) ? sine_rom[QTR - k] : sine_rom[k];
        return (q >= 2) ? -s : s;
    endfunction

    function automatic int q15_product(int a, int b);
        bit          neg;
        int unsigned m;
        neg = (a < 0) != (b < 0);
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 16384) >> 15;
        return neg ? -int'(m) : int'(m);
    endfunction

    function automatic logic [15:0] halved(int v);
        return 16'(v >>> 1);
    endfunction

    function automatic void clear_mesh_position();
        idx_phase = 0; ring_ctr = 0; seg_ctr = 0; corner_ctr = 0;
    endfunction

    // next record of the mesh stream
    function automatic t_mesh_rec next_mesh_record(bit restart);
        t_mesh_rec   rec;
        int unsigned S, R, r, s, a, b, pphi, pth, vnum;
        int          sp, cp, st, ct, nx, nz;
        S = seg_reg < uvs_pkg::SEG_MIN ? uvs_pkg::SEG_MIN : seg_reg;
        R = ring_reg < uvs_pkg::RING_MIN ? uvs_pkg::RING_MIN : ring_reg;
        if (restart) clear_mesh_position();
        if (idx_phase != 0) begin
            if (ring_ctr >= R || seg_ctr >= S || corner_ctr > uvs_pkg::CORNER_LAST)
                clear_mesh_position();
        end else if (ring_ctr > R || seg_ctr > S) begin
            clear_mesh_position();
        end
        rec = '0;
        r = ring_ctr;
        s = seg_ctr;
        if (idx_phase == 0) begin
            pphi = (r * (1 << PB) + R) / (2 * R);
            pth  = (s * (2 << PB) + S) / (2 * S);
            sp = sine_of(pphi);
            cp = sine_of(pphi + QTR);
            st = sine_of(pth);
            ct = sine_of(pth + QTR);
            nx = q15_product(sp, ct);
            nz = q15_product(sp, st);
            rec.kind = uvs_pkg::KIND_VERTEX;
            rec.nx = 16'(nx); rec.ny = 16'(cp); rec.nz = 16'(nz);
            rec.px = halved(nx); rec.py = halved(cp); rec.pz = halved(nz);
            rec.u = 17'((s * 65536) / S);
            rec.v = 17'((r * 65536) / R);
            vnum = r * (S + 1) + s;
            rec.idx = 16'(vnum);
            if (s < S) seg_ctr = s + 1;
            else begin
                seg_ctr = 0;
                if (r < R) ring_ctr = r + 1;
                else begin
                    ring_ctr = 0; corner_ctr = 0; idx_phase = 1;
                end
            end
        end else begin
            a = r * (S + 1) + s;
            b = a + S + 1;
            rec.kind = uvs_pkg::KIND_INDEX;
            case (corner_ctr)
                0: rec.idx = 16'(a);
                1, 4: rec.idx = 16'(b);
                2, 3: rec.idx = 16'(a + 1);
                default: rec.idx = 16'(b + 1);
            endcase
            if (corner_ctr < uvs_pkg::CORNER_LAST) corner_ctr++;
            else begin
                corner_ctr = 0;
                if (s + 1 < S) seg_ctr = s + 1;
                else begin
                    seg_ctr = 0;
                    if (r + 1 < R) ring_ctr = r + 1;
                    else begin
                        rec.last = 1'b1;
                        clear_mesh_position();
                    end
                end
            end
        end
        return rec;
    endfunction

    // send one request, predict its record
    task automatic send_request(bit restart);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'($urandom_range(127)), restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_recs.push_back(next_mesh_record(restart));
        @(negedge i_clk);
    endtask

    task automatic drain_records();
        s_axis_tvalid <= 1'b0;
        while (pending_recs.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // register write, block idle
    task automatic write_count(logic regsel, logic [31:0] val);
        drain_records();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(regsel) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (regsel == uvs_pkg::REG_SEGMENTS) seg_reg = val & 8'hff;
        else ring_reg = val & 8'hff;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_mesh_rec got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.kind = m_axis_tuser;
            got.last = m_axis_tlast;
            {got.idx, got.v, got.u, got.pz, got.py, got.px, got.nz, got.ny, got.nx} =
                m_axis_tdata[145:0];
            if (pending_recs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record %h", got);
            end else begin
                want = pending_recs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);

    task automatic test_default_mesh();
        // restart first, then the first vertex records of the default mesh
        send_request(1'b1);
        for (int i = 0; i < 20; i++) send_request(1'b0);
    endtask

    task automatic test_clamped_counts();
        // both counts below their floors, full mesh and wrap
        write_count(uvs_pkg::REG_SEGMENTS, 32'd0);
        write_count(uvs_pkg::REG_RINGS, 32'd0);
        send_request(1'b1);
        for (int i = 0; i < 20 + 12 + 36 + 4; i++) send_request(1'b0);
    endtask

    task automatic test_out_of_range();
        // shrink counts mid-stream, stream restarts itself
        write_count(uvs_pkg::REG_SEGMENTS, 32'd200);
        write_count(uvs_pkg::REG_RINGS, 32'd255);
        for (int i = 0; i < 10; i++) send_request(1'b0);
        write_count(uvs_pkg::REG_SEGMENTS, 32'd3);
        write_count(uvs_pkg::REG_RINGS, 32'd2);
        for (int i = 0; i < 5; i++) send_request(1'b0);
    endtask

    task automatic test_random_meshes();
        int n;
        n = 0;
        while (n < 850) begin
            if ($urandom_range(3) == 0) begin
                write_count(uvs_pkg::REG_SEGMENTS, $urandom_range(3) == 0 ?
                            {24'($urandom), 8'($urandom)} : 32'($urandom_range(8)));
                write_count(uvs_pkg::REG_RINGS, $urandom_range(3) == 0 ?
                            {24'($urandom), 8'($urandom)} : 32'($urandom_range(6)));
            end
            idle_pct = ($urandom_range(4) == 0) ? 0 : 35;
            for (int i = $urandom_range(150, 40); i > 0 && n < 850; i--, n++)
                send_request($urandom_range(40) == 0);
            if (n > 400 && n < 600) drain_records();
        end
        idle_pct = 35;
    endtask

    initial begin
        for (int k = 0; k <= QTR; k++) sine_rom[k] = quarter_sine(k);
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_pct = 35;
        seg_reg = 16; ring_reg = 8;
        clear_mesh_position();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_mesh();
        test_clamped_counts();
        test_out_of_range();
        test_random_meshes();
        drain_records();
        if (mismatches == 0 && pending_recs.size() == 0)
            $display("uv_sphere_mesh_generator_tb OK");
        else
            $display("uv_sphere_mesh_generator_tb NOT OK");
        $finish;
    end

endmodule
